FILE: rtl/itl_pkg.sv
// ----------------------------------------------------------------------------
// itl_pkg
// Shared constants, codes and controller/datapath link types for the
// interpolated table lookup.
// ----------------------------------------------------------------------------
package itl_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int FRAC_W      = 16;

   typedef enum logic [2:0] {
      KIND_EMPTY  = 3'd0,
      KIND_LOW    = 3'd1,
      KIND_HIGH   = 3'd2,
      KIND_INTERP = 3'd3,
      KIND_EQUAL  = 3'd4
   } result_kind_type;

   typedef enum logic [1:0] {
      ADDR_MID  = 2'd0,
      ADDR_LAST = 2'd1,
      ADDR_LO   = 2'd2,
      ADDR_LOM1 = 2'd3
   } addr_sel_type;

   typedef enum logic [1:0] {
      RES_ZERO   = 2'd0,
      RES_RDVAL  = 2'd1,
      RES_V0     = 2'd2,
      RES_INTERP = 2'd3
   } res_sel_type;

   typedef struct packed {
      logic            accept;
      logic            init;
      logic            cmp;
      addr_sel_type    addr_sel;
      logic            latch0;
      logic            latch1;
      logic            prep;
      logic            div_step;
      logic            mul;
      logic            res_load;
      res_sel_type     res_sel;
      result_kind_type res_kind;
      logic            out_load;
   } cmd_type;

   typedef struct packed {
      logic query;
      logic n_zero;
      logic lo_lt_hi;
      logic lo_ge_n;
      logic lo_zero;
      logic t_equal;
      logic alpha_fixed;
      logic div_last;
   } status_type;

endpackage

FILE: rtl/itl_if.sv
// ----------------------------------------------------------------------------
// itl_if
// Valid/ready channels of the interpolated table lookup: request, response
// and register write.
// ----------------------------------------------------------------------------
interface itl_req_if import itl_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    mode;
   logic [IDX_W-1:0]        entry_index;
   logic signed [31:0]      sample_time;
   logic signed [31:0]      sample_value;

   modport source (output valid, mode, entry_index, sample_time, sample_value,
                   input ready);
   modport sink   (input valid, mode, entry_index, sample_time, sample_value,
                   output ready);
endinterface

interface itl_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] interp_value;
   logic [2:0]         result_kind;

   modport source (output valid, interp_value, result_kind, input ready);
   modport sink   (input valid, interp_value, result_kind, output ready);
endinterface

interface itl_csr_if import itl_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] entry_count;

   modport source (output valid, entry_count, input ready);
   modport sink   (input valid, entry_count, output ready);
endinterface

FILE: rtl/interpolated_table_lookup.sv
// ----------------------------------------------------------------------------
// interpolated_table_lookup
// Piecewise linear lookup over a loaded table of time and value pairs.
// ----------------------------------------------------------------------------
// Usage:
//   req  : mode 0 writes entry_index with sample_time/sample_value, no response.
//          mode 1 queries the table at sample_time and gives one response.
//   rsp  : interp_value (signed Q16.16) and result_kind.
//   csr  : writes entry_count, always ready; write only while idle.
// Sequence: a load item writes its table slot and returns to idle. A query runs
//   binary search steps (at most ceil(log2(entry_count))+1 steps, one table read each),
//   then a neighbour fetch, a bit-serial division for the 16 fraction bits and
//   a multiply and add; the division is skipped when the weight is fixed at zero or one.
//   The single read port of the table memories sets the search rate.
// Reset: entry_count clears to zero and the table contents are undefined
//   until written; no clearing pass runs.
// Stall: a finished response sits in the response register while the next
//   item is accepted; a query whose result is ready waits until the response register is free.
// ----------------------------------------------------------------------------
module interpolated_table_lookup import itl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   itl_req_if.sink  req_if,
   itl_rsp_if.source rsp_if,
   itl_csr_if.sink  csr_if
);

   cmd_type    cmd;
   status_type status;

   assign csr_if.ready = 1'b1;

   itl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   itl_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_mode         (req_if.mode),
      .req_entry_index  (req_if.entry_index),
      .req_sample_time  (req_if.sample_time),
      .req_sample_value (req_if.sample_value),
      .csr_write        (csr_if.valid),
      .csr_entry_count  (csr_if.entry_count),
      .cmd              (cmd),
      .status           (status),
      .rsp_interp_value (rsp_if.interp_value),
      .rsp_result_kind  (rsp_if.result_kind)
   );

endmodule

FILE: rtl/itl_datapath.sv
// ----------------------------------------------------------------------------
// itl_datapath
// Table memories, search bounds, divider, multiplier and result registers.
// ----------------------------------------------------------------------------
module itl_datapath import itl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_mode,
   input  logic [IDX_W-1:0]   req_entry_index,
   input  logic signed [31:0] req_sample_time,
   input  logic signed [31:0] req_sample_value,
   input  logic               csr_write,
   input  logic [CNT_W-1:0]   csr_entry_count,
   input  cmd_type            cmd,
   output status_type         status,
   output logic signed [31:0] rsp_interp_value,
   output logic [2:0]         rsp_result_kind
);

   logic signed [31:0] time_mem [TABLE_DEPTH];
   logic signed [31:0] value_mem [TABLE_DEPTH];

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   n_ff, lo_ff, hi_ff;
   logic               mode_ff;
   logic signed [31:0] t_ff, t0_ff, v0_ff;
   logic signed [31:0] rd_time_ff, rd_value_ff;
   logic signed [32:0] dt_ff, den_ff, dv_ff;
   logic [32:0]        rem_ff, dsr_ff;
   logic [FRAC_W:0]    alpha_ff;
   logic [3:0]         cnt_ff;
   logic signed [50:0] prod_ff;
   logic signed [31:0] res_ff, out_value_ff;
   logic [2:0]         res_kind_ff, out_kind_ff;

   logic [CNT_W:0]     mid_sum;
   logic [IDX_W-1:0]   mid;
   logic [IDX_W-1:0]   rd_addr;
   logic [CNT_W-1:0]   lo_m1, n_m1;
   logic [32:0]        mag_dt, mag_den;
   logic               neg;
   logic [33:0]        rem2;
   logic [33:0]        rem2_sub;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[IDX_W:1];
   assign lo_m1   = lo_ff - CNT_W'(1);
   assign n_m1    = n_ff - CNT_W'(1);

   always_comb begin
      case (cmd.addr_sel)
         ADDR_MID:  rd_addr = mid;
         ADDR_LAST: rd_addr = n_m1[IDX_W-1:0];
         ADDR_LO:   rd_addr = lo_ff[IDX_W-1:0];
         ADDR_LOM1: rd_addr = lo_m1[IDX_W-1:0];
         default:   rd_addr = mid;
      endcase
   end

   assign mag_dt   = dt_ff[32] ? 33'(-dt_ff) : 33'(dt_ff);
   assign mag_den  = den_ff[32] ? 33'(-den_ff) : 33'(den_ff);
   assign neg      = dt_ff[32] ^ den_ff[32];
   assign rem2     = {rem_ff, 1'b0};
   assign rem2_sub = rem2 - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (cmd.accept && !req_mode) begin
         time_mem[req_entry_index]  <= req_sample_time;
         value_mem[req_entry_index] <= req_sample_value;
      end
      rd_time_ff  <= time_mem[rd_addr];
      rd_value_ff <= value_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_write) begin
         count_ff <= csr_entry_count;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff <= req_mode;
         t_ff    <= req_sample_time;
         n_ff    <= (count_ff > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_ff;
      end
      if (cmd.init) begin
         lo_ff <= '0;
         hi_ff <= n_ff;
      end else if (cmd.cmp) begin
         if (rd_time_ff < t_ff) begin
            lo_ff <= {1'b0, mid} + CNT_W'(1);
         end else begin
            hi_ff <= {1'b0, mid};
         end
      end
      if (cmd.latch0) begin
         t0_ff <= rd_time_ff;
         v0_ff <= rd_value_ff;
      end
      if (cmd.latch1) begin
         dt_ff  <= 33'(t_ff) - 33'(t0_ff);
         den_ff <= 33'(rd_time_ff) - 33'(t0_ff);
         dv_ff  <= 33'(rd_value_ff) - 33'(v0_ff);
      end
      if (cmd.prep) begin
         rem_ff <= mag_dt;
         dsr_ff <= mag_den;
         cnt_ff <= '0;
         // clamp to zero or one before any division step
         if (dt_ff == '0 || neg) begin
            alpha_ff <= '0;
         end else if (mag_dt >= mag_den) begin
            alpha_ff <= (FRAC_W+1)'(1) << FRAC_W;
         end else begin
            alpha_ff <= '0;
         end
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + 4'd1;
         if (!rem2_sub[33]) begin
            rem_ff   <= rem2_sub[32:0];
            alpha_ff <= {alpha_ff[FRAC_W-1:0], 1'b1};
         end else begin
            rem_ff   <= rem2[32:0];
            alpha_ff <= {alpha_ff[FRAC_W-1:0], 1'b0};
         end
      end
      if (cmd.mul) begin
         prod_ff <= 51'($signed({1'b0, alpha_ff}) * dv_ff);
      end
      if (cmd.res_load) begin
         res_kind_ff <= cmd.res_kind;
         case (cmd.res_sel)
            RES_ZERO:   res_ff <= '0;
            RES_RDVAL:  res_ff <= rd_value_ff;
            RES_V0:     res_ff <= v0_ff;
            RES_INTERP: res_ff <= v0_ff + prod_ff[47:16];
            default:    res_ff <= '0;
         endcase
      end
      if (cmd.out_load) begin
         out_value_ff <= res_ff;
         out_kind_ff  <= res_kind_ff;
      end
   end

   always_comb begin
      status.query       = mode_ff;
      status.n_zero      = (n_ff == '0);
      status.lo_lt_hi    = (lo_ff < hi_ff);
      status.lo_ge_n     = (lo_ff >= n_ff);
      status.lo_zero     = (lo_ff == '0);
      status.t_equal     = (den_ff == '0);
      status.alpha_fixed = (dt_ff == '0) || neg || (mag_dt >= mag_den);
      status.div_last    = (cnt_ff == 4'd15);
   end

   assign rsp_interp_value = out_value_ff;
   assign rsp_result_kind  = out_kind_ff;

endmodule

FILE: rtl/itl_ctrl.sv
// ----------------------------------------------------------------------------
// itl_ctrl
// Sequencer for load and query items: search, neighbour fetch, divide,
// multiply and hand-off to the response register.
// ----------------------------------------------------------------------------
module itl_ctrl import itl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_START  = 13'b0000000000010,
      S_CHECK  = 13'b0000000000100,
      S_CMP    = 13'b0000000001000,
      S_SELECT = 13'b0000000010000,
      S_LAST   = 13'b0000000100000,
      S_RD1    = 13'b0000001000000,
      S_RD2    = 13'b0000010000000,
      S_PREP   = 13'b0000100000000,
      S_DIV    = 13'b0001000000000,
      S_MUL    = 13'b0010000000000,
      S_ADD    = 13'b0100000000000,
      S_FINISH = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.addr_sel = ADDR_MID;
      cmd.res_sel  = RES_ZERO;
      cmd.res_kind = KIND_EMPTY;
      case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.init = 1'b1;
            state_in = status.query ? S_CHECK : S_IDLE;
         end
         S_CHECK: begin
            if (status.n_zero) begin
               cmd.res_load = 1'b1;
               state_in     = S_FINISH;
            end else if (status.lo_lt_hi) begin
               state_in = S_CMP;
            end else begin
               state_in = S_SELECT;
            end
         end
         S_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = S_CHECK;
         end
         S_SELECT: begin
            if (status.lo_ge_n) begin
               cmd.addr_sel = ADDR_LAST;
               state_in     = S_LAST;
            end else if (status.lo_zero) begin
               cmd.addr_sel = ADDR_LO;
               state_in     = S_LAST;
            end else begin
               cmd.addr_sel = ADDR_LOM1;
               state_in     = S_RD1;
            end
         end
         S_LAST: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_RDVAL;
            cmd.res_kind = status.lo_ge_n ? KIND_HIGH : KIND_LOW;
            state_in     = S_FINISH;
         end
         S_RD1: begin
            cmd.latch0   = 1'b1;
            cmd.addr_sel = ADDR_LO;
            state_in     = S_RD2;
         end
         S_RD2: begin
            cmd.latch1 = 1'b1;
            state_in   = S_PREP;
         end
         S_PREP: begin
            if (status.t_equal) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_V0;
               cmd.res_kind = KIND_EQUAL;
               state_in     = S_FINISH;
            end else begin
               cmd.prep = 1'b1;
               state_in = status.alpha_fixed ? S_MUL : S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ADD;
         end
         S_ADD: begin
            // form the sum once the product is registered
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_INTERP;
            cmd.res_kind = KIND_INTERP;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: bench/itl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itl_checker
// Watches the request, response and register channels of the table lookup.
// It keeps its own copy of the table and the entry count, works out the
// expected value and kind for each query, and compares each response with
// the oldest one still waiting.
// ----------------------------------------------------------------------------
module itl_checker import itl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   itl_req_if.sink req_if,
   itl_rsp_if.sink rsp_if,
   itl_csr_if.sink csr_if,
   output int      fail_count,
   output int      pending_count,
   output int      query_count
);

   typedef struct {
      logic signed [31:0] value;
      result_kind_type    kind;
   } lookup_result_type;

   logic signed [31:0] time_mem  [TABLE_DEPTH];
   logic signed [31:0] value_mem [TABLE_DEPTH];
   int unsigned        count_shadow;
   lookup_result_type  expected_q[$];

   function automatic lookup_result_type interpolate(input logic signed [31:0] t);
      lookup_result_type r;
      int unsigned n, lo, hi, mid;
      longint t0, t1, v0, v1, alpha, p, res;
      n = (count_shadow > TABLE_DEPTH) ? TABLE_DEPTH : count_shadow;
      if (n == 0) begin
         r.value = 0;
         r.kind  = KIND_EMPTY;
         return r;
      end
      lo = 0;
      hi = n;
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         if (time_mem[mid] < t) lo = mid + 1;
         else hi = mid;
      end
      if (lo >= n) begin
         r.value = value_mem[n-1];
         r.kind  = KIND_HIGH;
      end else if (lo == 0) begin
         r.value = value_mem[0];
         r.kind  = KIND_LOW;
      end else begin
         t0 = time_mem[lo-1];
         t1 = time_mem[lo];
         v0 = value_mem[lo-1];
         v1 = value_mem[lo];
         if (t0 == t1) begin
            r.value = v0;
            r.kind  = KIND_EQUAL;
         end else begin
            // signed division in SV truncates toward zero
            alpha = ((longint'(t) - t0) * 65536) / (t1 - t0);
            if (alpha < 0) alpha = 0;
            if (alpha > 65536) alpha = 65536;
            p = alpha * (v1 - v0);
            res = v0 + (p >>> 16);
            if (res > 64'sd2147483647) res = 64'sd2147483647;
            if (res < -64'sd2147483648) res = -64'sd2147483648;
            r.value = res[31:0];
            r.kind  = KIND_INTERP;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      fail_count++;
   endtask

   initial begin
      fail_count    = 0;
      pending_count = 0;
      query_count   = 0;
      count_shadow  = 0;
   end

   always @(posedge clock) begin
      lookup_result_type want;
      if (reset) begin
         count_shadow = 0;
      end else begin
         if (csr_if.valid && csr_if.ready) count_shadow = csr_if.entry_count;
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("response with no query waiting");
            end else begin
               want = expected_q.pop_front();
               if (rsp_if.interp_value !== want.value)
                  report_mismatch($sformatf("value %h, want %h",
                                            rsp_if.interp_value, want.value));
               if (rsp_if.result_kind !== want.kind)
                  report_mismatch($sformatf("kind %0d, want %0d",
                                            rsp_if.result_kind, want.kind));
            end
         end
         if (req_if.valid && req_if.ready) begin
            if (req_if.mode) begin
               expected_q.insert(expected_q.size(), interpolate(req_if.sample_time));
               query_count++;
            end else begin
               time_mem[req_if.entry_index]  = req_if.sample_time;
               value_mem[req_if.entry_index] = req_if.sample_value;
            end
         end
         pending_count = expected_q.size();
      end
   end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Loads sorted and unsorted tables of several sizes, sets several entry
// counts and queries below, between, on and past the entries.
// ----------------------------------------------------------------------------
module tb import itl_pkg::*; ();

   logic clock;
   logic reset;
   int   fail_count, pending_count, query_count;
   int   load_count;

   itl_req_if req_if ();
   itl_rsp_if rsp_if ();
   itl_csr_if csr_if ();

   interpolated_table_lookup dut (
      .clock (clock), .reset (reset),
      .req_if (req_if.sink), .rsp_if (rsp_if.source), .csr_if (csr_if.sink)
   );

   itl_checker checker_inst (
      .clock (clock), .reset (reset),
      .req_if (req_if.sink), .rsp_if (rsp_if.sink), .csr_if (csr_if.sink),
      .fail_count (fail_count), .pending_count (pending_count),
      .query_count (query_count)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // random stall on the response side
   int unsigned stall_left;
   int unsigned stall_draw;
   initial begin
      rsp_if.ready = 0;
      stall_left   = 0;
   end
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         stall_draw = $urandom_range(0, 4);
         stall_left   <= (stall_draw == 0) ? 0 : stall_draw - 1;
         rsp_if.ready <= (stall_draw == 0);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   task automatic send_item(input logic mode, input logic [IDX_W-1:0] idx,
                            input logic signed [31:0] t,
                            input logic signed [31:0] v);
      int unsigned gap;
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.mode         <= mode;
      req_if.entry_index  <= idx;
      req_if.sample_time  <= t;
      req_if.sample_value <= v;
      do @(posedge clock); while (!req_if.ready);
      if (!mode) load_count++;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_count(input int unsigned n);
      drain();
      csr_if.valid       <= 1;
      csr_if.entry_count <= CNT_W'(n);
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 0;
   endtask

   // load slots 0..n-1 with nondecreasing times, some repeated
   task automatic load_sorted(input int unsigned n, input int step_max);
      longint t;
      t = -longint'($urandom_range(0, 2000));
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(0, 7) != 0) t += $urandom_range(1, step_max);
         if (t > 64'sd2147483647) t = 64'sd2147483647;
         send_item(1'b0, IDX_W'(i), t[31:0], $urandom());
      end
   endtask

   task automatic query(input logic signed [31:0] t);
      send_item(1'b1, IDX_W'($urandom()), t, $urandom());
   endtask

   int unsigned n;
   initial begin
      reset = 1;
      load_count = 0;
      req_if.valid = 0; req_if.mode = 0; req_if.entry_index = 0;
      req_if.sample_time = 0; req_if.sample_value = 0;
      csr_if.valid = 0; csr_if.entry_count = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty table, extremes, equal times
      query(32'sh8000_0000);
      query(0);
      send_item(1'b0, IDX_W'(0), 32'sh8000_0000, 32'sh8000_0000);
      send_item(1'b0, IDX_W'(1), -100, 32'sh7fff_ffff);
      send_item(1'b0, IDX_W'(2), -100, 32'sh0001_0000);
      send_item(1'b0, IDX_W'(3), 100, 32'sh8000_0000);
      send_item(1'b0, IDX_W'(4), 32'sh7fff_ffff, 32'sh7fff_ffff);
      set_count(5);
      query(32'sh8000_0000);
      query(32'sh8000_0001);
      query(-101);
      query(-100);
      query(-99);
      query(0);
      query(100);
      query(101);
      query(32'sh7fff_fffe);
      query(32'sh7fff_ffff);
      set_count(1);
      query(32'sh8000_0000);
      query(32'sh7fff_ffff);
      // unsorted table: search runs as is
      send_item(1'b0, IDX_W'(1), 500, 32'sh0000_1234);
      send_item(1'b0, IDX_W'(2), -500, 32'sh7fff_0000);
      send_item(1'b0, IDX_W'(3), 0, -32'sh0001_0000);
      set_count(4);
      query(-400);
      query(250);

      // random phases: mostly sorted small tables, some noise rewrites
      while (query_count + load_count < 390) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                         : $urandom_range(0, 12);
         set_count(0);
         if (n > 0) load_sorted(n, ($urandom_range(0, 1)) ? 50 : 32'h3fff_ffff);
         for (int k = 0; k < 3 && n > 1; k++)
            if ($urandom_range(0, 3) == 0)
               send_item(1'b0, IDX_W'($urandom_range(0, n - 1)), $urandom(),
                         $urandom());
         set_count(n);
         for (int k = 0; k < 20; k++) begin
            if ($urandom_range(0, 2) == 0) query($urandom());
            else query($urandom_range(0, 60000) - 3000);
         end
      end

      drain();
      $display("Covered %0d queries and %0d loads over table sizes 0 to 40,",
               query_count, load_count);
      $display("with sorted, repeated-time and unsorted tables and random stalls.");
      if (fail_count == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb NOT OK");
      $finish;
   end

endmodule
